>>> design/srpm_pkg.sv
// Shared constants and types of the send/receive pair matcher.
`default_nettype none

package srpm_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int RANK_BITS   = 20;

	localparam int IDX_W     = $clog2(TABLE_DEPTH);
	localparam int CNT_W     = $clog2(TABLE_DEPTH + 1);
	localparam int RANK_IO_W = 20;
	localparam int TAG_W     = 31;
	localparam int LEN_W     = 31;
	localparam int TIME_W    = 63;
	localparam int ORDER_W   = 32;

	localparam int S_FIELDS_W = 2 * RANK_IO_W + TAG_W + LEN_W + TIME_W;
	localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
	localparam int M_FIELDS_W = 2 * RANK_IO_W + TAG_W + LEN_W + 2 * TIME_W;
	localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;
	localparam int M_TUSER_W  = 2;

	typedef logic [RANK_BITS-1:0] rank_t;
	typedef logic [IDX_W-1:0]     idx_t;

	// One pending event; owner is the receiving rank, peer the sending rank.
	typedef struct packed {
		logic                is_send;
		rank_t               owner;
		rank_t               peer;
		logic [TAG_W-1:0]    tag;
		logic [LEN_W-1:0]    length;
		logic [TIME_W-1:0]   time_stamp;
		logic [ORDER_W-1:0]  order;
	} entry_t;

	// Table update for one cycle: store a new entry and/or free a matched one.
	typedef struct packed {
		logic we;
		idx_t waddr;
		logic clr;
		idx_t caddr;
	} tbl_cmd_t;

endpackage

`default_nettype wire

>>> design/srpm_table.sv
// Pending-event memory with registered read and per-entry valid flags.
`default_nettype none

module srpm_table (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire srpm_pkg::tbl_cmd_t              cmd,
	input  wire srpm_pkg::entry_t                wdata,
	input  wire srpm_pkg::idx_t                  raddr,
	output srpm_pkg::entry_t                     rdata,
	output logic [srpm_pkg::TABLE_DEPTH-1:0]     valid
);
	import srpm_pkg::*;

	entry_t mem [TABLE_DEPTH];

	// Payload storage; contents are only looked at behind a set valid flag.
	always_ff @(posedge clk) begin
		if (cmd.we) begin
			mem[cmd.waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid <= '0;
		end else begin
			if (cmd.we) begin
				valid[cmd.waddr] <= 1'b1;
			end
			if (cmd.clr) begin
				valid[cmd.caddr] <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

>>> design/send_receive_pair_matcher.sv
// Top level of the send/receive pair matcher: event intake, table scan and arrow output.
`default_nettype none

// Pairs message send and receive events. Each input transaction is one event: s_tuser
// carries the mode (0 send, 1 receive) and s_tdata the ranks, tag, length and timestamp.
// A send looks for the oldest pending receive held at its destination that names this
// sender and tag; a receive looks for the oldest pending send to its own rank from the
// named source with the same tag. A hit emits one arrow transaction and frees the entry;
// a miss stores the event in the lowest free entry with no output, and a miss on a full
// table emits a drop transaction (result_kind 1, all other fields zero). Pending events
// live in a TABLE_DEPTH-entry memory with a registered read; each event reads every
// entry once, one per cycle, and holds the block with s_tready low from acceptance
// through a read issue per entry, the drain of the compare pipeline, a check that the
// pipeline is empty, and a final step that updates the table and loads the output
// register. If the event yields a result while a previous one still sits unaccepted
// there, that final step holds until m_tready frees it; a store does not wait. No
// clearing pass is needed after reset; the entry valid flags clear at once. Age is the
// 32-bit distance from the arrival counter, so an entry outlived by 2^32 later stores
// loses its rank.
module send_receive_pair_matcher (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	// [19:0] local_rank, [39:20] remote_rank, [70:40] msg_tag, [101:71] msg_length,
	// [164:102] event_time, [167:165] zero
	input  wire logic [srpm_pkg::S_TDATA_W-1:0] s_tdata,
	// [0] mode
	input  wire logic                           s_tuser,
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	// [19:0] arrow_src, [39:20] arrow_dest, [70:40] arrow_tag, [101:71] arrow_length,
	// [164:102] arrow_start, [227:165] arrow_end, [231:228] zero
	output logic [srpm_pkg::M_TDATA_W-1:0]      m_tdata,
	// [0] result_kind, [1] direction
	output logic [srpm_pkg::M_TUSER_W-1:0]      m_tuser
);
	import srpm_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SCAN   = 3'b010,
		ST_FINISH = 3'b100
	} state_t;

	localparam logic MODE_SEND = 1'b0;
	localparam logic KIND_ARROW = 1'b0;
	localparam logic KIND_DROP  = 1'b1;
	localparam logic DIR_LEFT   = 1'b0;
	localparam logic DIR_RIGHT  = 1'b1;

	state_t state_q;

	// Current event, held for the whole scan.
	logic              mode_q;
	rank_t             local_q;
	rank_t             remote_q;
	logic [TAG_W-1:0]  tag_q;
	logic [LEN_W-1:0]  len_q;
	logic [TIME_W-1:0] time_q;

	logic [ORDER_W-1:0] cnt_q;
	logic [CNT_W-1:0]   issue_q;

	// Scan pipeline: s1 has read data, s2 has the compare result.
	logic               vld_s1;
	idx_t               idx_s1;
	logic               vld_s2;
	logic               hit_s2;
	idx_t               idx_s2;
	logic [ORDER_W-1:0] age_s2;
	logic [TIME_W-1:0]  time_s2;
	rank_t              peer_s2;
	logic [LEN_W-1:0]   len_s2;

	// Oldest hit so far and lowest free entry so far.
	logic               found_q;
	idx_t               best_idx_q;
	logic [ORDER_W-1:0] best_age_q;
	logic [TIME_W-1:0]  best_time_q;
	rank_t              best_peer_q;
	logic [LEN_W-1:0]   best_len_q;
	logic               free_found_q;
	idx_t               free_idx_q;

	logic                   m_tvalid_q;
	logic [M_TDATA_W-1:0]   m_tdata_q;
	logic [M_TUSER_W-1:0]   m_tuser_q;

	tbl_cmd_t                tbl_cmd;
	entry_t                  tbl_wdata;
	idx_t                    tbl_raddr;
	entry_t                  tbl_rdata;
	logic [TABLE_DEPTH-1:0]  tbl_valid;

	logic  in_acc;
	logic  issuing;
	logic  scan_done;
	logic  s1_hit;
	rank_t key_owner;
	rank_t key_peer;
	logic  need_result;
	logic  out_free;
	logic  finish_go;
	logic  out_load;

	logic [M_TDATA_W-1:0] res_tdata;
	logic [M_TUSER_W-1:0] res_tuser;
	logic [RANK_IO_W-1:0] res_src;
	logic [RANK_IO_W-1:0] res_dest;
	logic [LEN_W-1:0]     res_len;
	logic                 res_dir;

	srpm_table u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (tbl_cmd),
		.wdata  (tbl_wdata),
		.raddr  (tbl_raddr),
		.rdata  (tbl_rdata),
		.valid  (tbl_valid)
	);

	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;

	// Entries are kept under the receiving rank; the sender is the peer.
	assign key_owner = (mode_q == MODE_SEND) ? remote_q : local_q;
	assign key_peer  = (mode_q == MODE_SEND) ? local_q : remote_q;

	assign issuing   = (state_q == ST_SCAN) && (issue_q < CNT_W'(TABLE_DEPTH));
	assign scan_done = (state_q == ST_SCAN) && !issuing && !vld_s1 && !vld_s2;
	assign tbl_raddr = issue_q[IDX_W-1:0];

	// A send matches pending receives and vice versa.
	assign s1_hit = vld_s1 && tbl_valid[idx_s1] && (tbl_rdata.is_send == mode_q)
		&& (tbl_rdata.owner == key_owner) && (tbl_rdata.peer == key_peer)
		&& (tbl_rdata.tag == tag_q);

	// Final step: free the hit, or store the miss, or report a drop.
	assign need_result = found_q || !free_found_q;
	assign out_free    = !m_tvalid_q || m_tready;
	assign finish_go   = (state_q == ST_FINISH) && (!need_result || out_free);
	assign out_load    = finish_go && need_result;

	always_comb begin
		tbl_cmd       = '0;
		tbl_cmd.waddr = free_idx_q;
		tbl_cmd.caddr = best_idx_q;
		tbl_cmd.we    = finish_go && !found_q && free_found_q;
		tbl_cmd.clr   = finish_go && found_q;
	end

	always_comb begin
		tbl_wdata            = '0;
		tbl_wdata.is_send    = (mode_q == MODE_SEND);
		tbl_wdata.owner      = key_owner;
		tbl_wdata.peer       = key_peer;
		tbl_wdata.tag        = tag_q;
		tbl_wdata.length     = len_q;
		tbl_wdata.time_stamp = time_q;
		tbl_wdata.order      = cnt_q;
	end

	// Arrow fields: a send closes a left arrow, a receive a right arrow.
	always_comb begin
		if (mode_q == MODE_SEND) begin
			res_src  = RANK_IO_W'(local_q);
			res_dest = RANK_IO_W'(remote_q);
			res_len  = len_q;
			res_dir  = DIR_LEFT;
		end else begin
			res_src  = RANK_IO_W'(best_peer_q);
			res_dest = RANK_IO_W'(local_q);
			res_len  = best_len_q;
			res_dir  = DIR_RIGHT;
		end
		if (found_q) begin
			res_tdata = M_TDATA_W'({time_q, best_time_q, res_len, tag_q, res_dest, res_src});
			res_tuser = {res_dir, KIND_ARROW};
		end else begin
			res_tdata = '0;
			res_tuser = {DIR_LEFT, KIND_DROP};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (scan_done) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (finish_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Capture the event; ranks are compared on their low RANK_BITS bits.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			mode_q   <= s_tuser;
			local_q  <= rank_t'(s_tdata[RANK_IO_W-1:0]);
			remote_q <= rank_t'(s_tdata[2*RANK_IO_W-1:RANK_IO_W]);
			tag_q    <= s_tdata[2*RANK_IO_W+TAG_W-1:2*RANK_IO_W];
			len_q    <= s_tdata[2*RANK_IO_W+TAG_W+LEN_W-1:2*RANK_IO_W+TAG_W];
			time_q   <= s_tdata[S_FIELDS_W-1:2*RANK_IO_W+TAG_W+LEN_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q        <= '0;
			issue_q      <= '0;
			vld_s1       <= 1'b0;
			vld_s2       <= 1'b0;
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
		end else begin
			if (tbl_cmd.we) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (in_acc) begin
				issue_q      <= '0;
				found_q      <= 1'b0;
				free_found_q <= 1'b0;
			end else begin
				if (issuing) begin
					issue_q <= issue_q + 1'b1;
				end
				if (vld_s1 && !tbl_valid[idx_s1] && !free_found_q) begin
					free_found_q <= 1'b1;
				end
				if (vld_s2 && hit_s2 && (!found_q || age_s2 > best_age_q)) begin
					found_q <= 1'b1;
				end
			end
			vld_s1 <= issuing;
			vld_s2 <= vld_s1;
		end
	end

	// Scan datapath: compare and note the lowest free entry in s1, pick the oldest in s2.
	always_ff @(posedge clk) begin
		idx_s1  <= tbl_raddr;
		hit_s2  <= s1_hit;
		idx_s2  <= idx_s1;
		age_s2  <= cnt_q - tbl_rdata.order;
		time_s2 <= tbl_rdata.time_stamp;
		peer_s2 <= tbl_rdata.peer;
		len_s2  <= tbl_rdata.length;
		if (vld_s1 && !tbl_valid[idx_s1] && !free_found_q) begin
			free_idx_q <= idx_s1;
		end
		if (vld_s2 && hit_s2 && (!found_q || age_s2 > best_age_q)) begin
			best_idx_q  <= idx_s2;
			best_age_q  <= age_s2;
			best_time_q <= time_s2;
			best_peer_q <= peer_s2;
			best_len_q  <= len_s2;
		end
	end

	// Output register; holds a result until the downstream takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= res_tdata;
			m_tuser_q <= res_tuser;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!m_tvalid_q || m_tready))
		else $error("result loaded over an unaccepted result");

	a_store_free: assert property (@(posedge clk) disable iff (!arst_n)
		tbl_cmd.we |-> !tbl_valid[tbl_cmd.waddr])
		else $error("store into an occupied entry");

	a_clear_valid: assert property (@(posedge clk) disable iff (!arst_n)
		tbl_cmd.clr |-> (tbl_valid[tbl_cmd.caddr] && !tbl_cmd.we))
		else $error("freeing an entry that is not pending");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		tbl_cmd.we |=> (cnt_q == $past(cnt_q) + 1'b1))
		else $error("arrival counter did not advance on store");

	a_pipe_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (!vld_s1 && !vld_s2))
		else $error("scan pipeline busy while idle");

endmodule

`default_nettype wire

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench of the send/receive pair matcher with a built-in pairing predictor.
module testbench;
	import srpm_pkg::*;

	localparam int HALF_PERIOD   = 10;
	localparam int BLOCK_LATENCY = TABLE_DEPTH + 4;
	localparam int RANDOM_EVENTS = 1000;
	localparam int MAX_WAIT      = 19;

	typedef logic [RANK_IO_W-1:0] rank_io_t;
	typedef logic [TAG_W-1:0]     tag_t;
	typedef logic [LEN_W-1:0]     len_t;
	typedef logic [TIME_W-1:0]    stamp_t;

	typedef enum logic {MODE_SEND = 1'b0, MODE_RECV = 1'b1} mode_e;
	typedef enum logic {KIND_ARROW = 1'b0, KIND_DROP = 1'b1} kind_e;
	typedef enum logic {DIR_LEFT = 1'b0, DIR_RIGHT = 1'b1} dir_e;

	localparam rank_io_t RANK_MAX  = '1;
	localparam tag_t     TAG_MAX   = '1;
	localparam len_t     LEN_MAX   = '1;
	localparam stamp_t   STAMP_MAX = '1;

	// One logged event as it enters the block
	typedef struct packed {
		mode_e    mode;
		rank_io_t local_rank;
		rank_io_t remote_rank;
		tag_t     tag;
		len_t     len;
		stamp_t   stamp;
	} msg_event_t;

	// One output transaction: an arrow or a drop report
	typedef struct packed {
		kind_e    kind;
		rank_io_t src;
		rank_io_t dest;
		tag_t     tag;
		len_t     len;
		stamp_t   t_start;
		stamp_t   t_end;
		dir_e     dir;
	} arrow_t;

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata  = '0;
	logic                 s_tuser  = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [M_TUSER_W-1:0] m_tuser;

	// Predictor state: pending events of the table and their arrival numbers
	entry_t             held [TABLE_DEPTH];
	bit                 held_valid [TABLE_DEPTH];
	logic [ORDER_W-1:0] arrival_no = '0;

	// Arrows and drop reports predicted but not yet seen on the master side
	arrow_t      awaited [$];
	int unsigned fault_count = 0;
	// Set to run both sides without any idle cycles
	bit          no_idle = 1'b0;

	send_receive_pair_matcher dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #HALF_PERIOD clk = ~clk;

	// Pair one accepted event with the oldest matching pending entry, or hold it in the table.
	// A send hunts for a receive kept under its destination that names it as source;
	// a receive hunts for a send kept under its own rank from the named source.
	function automatic void match_or_store(input msg_event_t ev);
		logic               want_send;
		rank_t              owner;
		rank_t              peer;
		int                 hit;
		logic [ORDER_W-1:0] age;
		logic [ORDER_W-1:0] best_age;
		arrow_t             res;
		want_send = (ev.mode == MODE_RECV);
		owner     = (ev.mode == MODE_SEND) ? ev.remote_rank : ev.local_rank;
		peer      = (ev.mode == MODE_SEND) ? ev.local_rank : ev.remote_rank;
		hit       = -1;
		best_age  = '0;
		res       = '0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			if (held_valid[i] && held[i].is_send == want_send && held[i].owner == owner &&
					held[i].peer == peer && held[i].tag == ev.tag) begin
				// age is the wrapping distance from the arrival counter
				age = arrival_no - held[i].order;
				if (hit < 0 || age > best_age) begin
					hit      = i;
					best_age = age;
				end
			end
		end
		if (hit >= 0) begin
			held_valid[hit] = 1'b0;
			res.kind    = KIND_ARROW;
			res.src     = peer;
			res.dest    = owner;
			res.tag     = ev.tag;
			// the length always comes from the send side
			res.len     = (ev.mode == MODE_SEND) ? ev.len : held[hit].length;
			res.t_start = held[hit].time_stamp;
			res.t_end   = ev.stamp;
			res.dir     = (ev.mode == MODE_SEND) ? DIR_LEFT : DIR_RIGHT;
			awaited.push_back(res);
			return;
		end
		// no partner: take the lowest free slot
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			if (!held_valid[i]) begin
				held_valid[i]         = 1'b1;
				held[i].is_send       = (ev.mode == MODE_SEND);
				held[i].owner         = owner;
				held[i].peer          = peer;
				held[i].tag           = ev.tag;
				held[i].length        = ev.len;
				held[i].time_stamp    = ev.stamp;
				held[i].order         = arrival_no;
				arrival_no            = arrival_no + 1'b1;
				return;
			end
		end
		// table full: report a drop with every other field zero
		res.kind = KIND_DROP;
		awaited.push_back(res);
	endfunction

	function automatic msg_event_t make_event(mode_e mode, rank_io_t lr, rank_io_t rr, tag_t tag,
			len_t len, stamp_t stamp);
		return '{mode, lr, rr, tag, len, stamp};
	endfunction

	function automatic rank_io_t rand_rank();
		return rank_io_t'($urandom);
	endfunction

	function automatic tag_t rand_tag();
		return tag_t'($urandom);
	endfunction

	function automatic len_t rand_len();
		return len_t'($urandom);
	endfunction

	function automatic stamp_t rand_stamp();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[TIME_W-1:0];
	endfunction

	// Event with every field random; almost never finds a partner
	function automatic msg_event_t fresh_event(mode_e mode);
		return make_event(mode, rand_rank(), rand_rank(), rand_tag(), rand_len(), rand_stamp());
	endfunction

	// Event that pairs with the pending entry idx
	function automatic msg_event_t answer_to(int idx);
		if (held[idx].is_send)
			return make_event(MODE_RECV, held[idx].owner, held[idx].peer, held[idx].tag,
				rand_len(), rand_stamp());
		return make_event(MODE_SEND, held[idx].peer, held[idx].owner, held[idx].tag,
			rand_len(), rand_stamp());
	endfunction

	// Random pending entry, or -1 when the table is empty
	function automatic int pick_held();
		int idx_q [$];
		for (int i = 0; i < TABLE_DEPTH; i++)
			if (held_valid[i])
				idx_q.push_back(i);
		if (idx_q.size() == 0)
			return -1;
		return idx_q[$urandom_range(0, idx_q.size() - 1)];
	endfunction

	function automatic int held_count();
		int n;
		n = 0;
		for (int i = 0; i < TABLE_DEPTH; i++)
			n += held_valid[i];
		return n;
	endfunction

	// Drive one event on the slave side after a random gap and predict it on acceptance.
	task automatic post_event(input msg_event_t ev);
		int unsigned gap;
		gap = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tuser  <= ev.mode;
		s_tdata  <= {{(S_TDATA_W - S_FIELDS_W){1'b0}}, ev.stamp, ev.len, ev.tag,
			ev.remote_rank, ev.local_rank};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		match_or_store(ev);
	endtask

	function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fault_count++;
		end
	endfunction

	// Compare every master-side transaction with the oldest prediction.
	always @(posedge clk) begin : check_arrows
		arrow_t got;
		arrow_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.kind = kind_e'(m_tuser[0]);
			got.dir  = dir_e'(m_tuser[1]);
			{got.t_end, got.t_start, got.len, got.tag, got.dest, got.src} = m_tdata[M_FIELDS_W-1:0];
			if (awaited.size() == 0) begin
				$error("result transaction with nothing predicted: kind %0h src %0h dest %0h",
					got.kind, got.src, got.dest);
				fault_count++;
			end else begin
				want = awaited.pop_front();
				check_field("result_kind", want.kind, got.kind);
				check_field("arrow_src", want.src, got.src);
				check_field("arrow_dest", want.dest, got.dest);
				check_field("arrow_tag", want.tag, got.tag);
				check_field("arrow_length", want.len, got.len);
				check_field("arrow_start", want.t_start, got.t_start);
				check_field("arrow_end", want.t_end, got.t_end);
				check_field("direction", want.dir, got.dir);
			end
		end
	end

	// Master side: hold off tready for a random stall, possibly none, once a result shows up.
	initial begin : sink
		int unsigned stall;
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
			if (stall > 0) begin
				@(negedge clk) m_tready <= 1'b0;
				do @(posedge clk); while (!m_tvalid);
				repeat (stall) @(negedge clk);
				m_tready <= 1'b1;
			end else begin
				@(negedge clk) m_tready <= 1'b1;
			end
			do @(posedge clk); while (!(m_tvalid && m_tready));
		end
	end

	// Extreme ranks, tags, lengths and timestamps in both arrow directions.
	// The receive's own length must never reach the arrow.
	task automatic test_extreme_fields();
		post_event(make_event(MODE_SEND, '0, RANK_MAX, TAG_MAX, LEN_MAX, STAMP_MAX));
		post_event(make_event(MODE_RECV, RANK_MAX, '0, TAG_MAX, '0, '0));
		post_event(make_event(MODE_RECV, '0, RANK_MAX, '0, LEN_MAX, STAMP_MAX));
		post_event(make_event(MODE_SEND, RANK_MAX, '0, '0, '0, '0));
	endtask

	// A rank sending to itself pairs like any other message, in either order.
	task automatic test_self_message();
		rank_io_t r;
		tag_t     t;
		r = rand_rank();
		t = rand_tag();
		post_event(make_event(MODE_SEND, r, r, t, rand_len(), rand_stamp()));
		post_event(make_event(MODE_RECV, r, r, t, rand_len(), rand_stamp()));
		post_event(make_event(MODE_RECV, r, r, t, rand_len(), rand_stamp()));
		post_event(make_event(MODE_SEND, r, r, t, rand_len(), rand_stamp()));
	endtask

	// Duplicate keys: the oldest pending entry must pair first, for sends and receives.
	task automatic test_oldest_first();
		rank_io_t a;
		rank_io_t b;
		tag_t     t;
		a = rand_rank();
		b = rand_rank();
		t = rand_tag();
		post_event(make_event(MODE_SEND, a, b, t, rand_len(), rand_stamp()));
		post_event(make_event(MODE_SEND, a, b, t ^ tag_t'(1), rand_len(), rand_stamp()));
		post_event(make_event(MODE_SEND, a, b, t, rand_len(), rand_stamp()));
		post_event(make_event(MODE_RECV, b, a, t, rand_len(), rand_stamp()));
		post_event(make_event(MODE_RECV, b, a, t, rand_len(), rand_stamp()));
		post_event(make_event(MODE_RECV, b, a, t ^ tag_t'(1), rand_len(), rand_stamp()));
		post_event(make_event(MODE_RECV, b, a, t, rand_len(), rand_stamp()));
		post_event(make_event(MODE_RECV, b, a, t, rand_len(), rand_stamp()));
		post_event(make_event(MODE_SEND, a, b, t, rand_len(), rand_stamp()));
		post_event(make_event(MODE_SEND, a, b, t, rand_len(), rand_stamp()));
	endtask

	// Keys that differ in one place, and a second send of the same key, must not pair.
	// Leave the leftovers pending; the table-full test drains them.
	task automatic test_near_misses();
		rank_io_t a;
		rank_io_t b;
		tag_t     t;
		a = rand_rank();
		b = rand_rank();
		t = rand_tag();
		post_event(make_event(MODE_SEND, a, b, t, rand_len(), rand_stamp()));
		post_event(make_event(MODE_RECV, b, a, t ^ tag_t'(1), rand_len(), rand_stamp()));
		post_event(make_event(MODE_RECV, b, a ^ rank_io_t'(1), t, rand_len(), rand_stamp()));
		post_event(make_event(MODE_RECV, b ^ rank_io_t'(1), a, t, rand_len(), rand_stamp()));
		post_event(make_event(MODE_SEND, a, b, t, rand_len(), rand_stamp()));
		post_event(make_event(MODE_RECV, b, a, t, rand_len(), rand_stamp()));
	endtask

	// Fill every slot, drop one send and one receive, pair on a full table, refill the
	// freed slot, then drain the table completely.
	task automatic test_table_full();
		int idx;
		while (held_count() < TABLE_DEPTH)
			post_event(fresh_event(mode_e'($urandom_range(0, 1))));
		post_event(fresh_event(MODE_SEND));
		post_event(fresh_event(MODE_RECV));
		post_event(answer_to(pick_held()));
		post_event(fresh_event(MODE_RECV));
		for (idx = pick_held(); idx >= 0; idx = pick_held())
			post_event(answer_to(idx));
	endtask

	// Mostly matching traffic over small rank and tag pools, plus near misses and noise.
	// Refresh the pools every hundred events and run some stretches with no idling.
	task automatic test_random_traffic();
		rank_io_t    ranks [4];
		tag_t        tags [3];
		msg_event_t  ev;
		int          idx;
		int unsigned pick;
		int unsigned b;
		for (int n = 0; n < RANDOM_EVENTS; n++) begin
			if (n % 100 == 0) begin
				no_idle = ((n / 100) % 4 == 3);
				foreach (ranks[i])
					ranks[i] = rand_rank();
				foreach (tags[i])
					tags[i] = rand_tag();
			end
			pick = $urandom_range(0, 99);
			idx  = pick_held();
			if (pick < 50 && idx >= 0) begin
				ev = answer_to(idx);
			end else if (pick < 60 && idx >= 0) begin
				// broken pairing: flip one key bit of a real partner
				ev = answer_to(idx);
				case ($urandom_range(0, 2))
					0: begin
						b = $urandom_range(0, TAG_W - 1);
						ev.tag[b] = ~ev.tag[b];
					end
					1: begin
						b = $urandom_range(0, RANK_IO_W - 1);
						ev.local_rank[b] = ~ev.local_rank[b];
					end
					default: begin
						b = $urandom_range(0, RANK_IO_W - 1);
						ev.remote_rank[b] = ~ev.remote_rank[b];
					end
				endcase
			end else if (pick < 90) begin
				ev = make_event(mode_e'($urandom_range(0, 1)), ranks[$urandom_range(0, 3)],
					ranks[$urandom_range(0, 3)], tags[$urandom_range(0, 2)], rand_len(),
					rand_stamp());
			end else begin
				ev = fresh_event(mode_e'($urandom_range(0, 1)));
			end
			post_event(ev);
		end
		no_idle = 1'b0;
	endtask

	initial begin : run_tests
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		test_extreme_fields();
		test_self_message();
		test_oldest_first();
		test_near_misses();
		test_table_full();
		test_random_traffic();
		@(negedge clk) s_tvalid <= 1'b0;
		// drain what is still predicted, then let the last scan finish
		while (awaited.size() != 0)
			@(posedge clk);
		repeat (2 * BLOCK_LATENCY) @(posedge clk);
		if (fault_count == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

	// Watchdog: roughly ten times the slowest legal run
	initial begin : watchdog
		#20_000_000;
		$display("testbench: errors");
		$finish;
	end

endmodule
